FILE: rtl/ucfr_pkg.sv
// Package for the command frame receiver: frame position codes, byte codes,
// result struct and per-command length/argument helpers. No dependencies.
`timescale 1ns / 1ps

package ucfr_pkg;

  localparam logic [7:0] BreakByte = 8'h00;
  localparam logic [7:0] SyncByte  = 8'h55;
  localparam logic [3:0] AddrReset = 4'h1;

  // Position of the next expected frame byte
  typedef enum logic [2:0] {
    POS_BREAK = 3'd0,
    POS_SYNC  = 3'd1,
    POS_ID    = 3'd2,
    POS_ARG0  = 3'd3,
    POS_ARG1  = 3'd4,
    POS_CKSUM = 3'd5
  } pos_e;

  typedef enum logic [2:0] {
    CMD_0 = 3'd0,
    CMD_1 = 3'd1,
    CMD_2 = 3'd2,
    CMD_3 = 3'd3,
    CMD_4 = 3'd4,
    CMD_5 = 3'd5,
    CMD_6 = 3'd6,
    CMD_7 = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] first_arg;
    logic [7:0] second_arg;
  } frame_res_t;

  // Position of the last (checksum) byte of a frame
  function automatic pos_e last_pos(input logic [2:0] cmd);
    pos_e p;
    case (cmd)
      CMD_1, CMD_5, CMD_6: p = POS_ARG1;
      CMD_3:               p = POS_CKSUM;
      default:             p = POS_ARG0;
    endcase
    return p;
  endfunction

  function automatic logic has_first_arg(input logic [2:0] cmd);
    return (cmd == CMD_1) || (cmd == CMD_3) || (cmd == CMD_5) || (cmd == CMD_6);
  endfunction

  function automatic logic has_second_arg(input logic [2:0] cmd);
    return cmd == CMD_3;
  endfunction

endpackage

FILE: rtl/uart_command_frame_receiver.sv
// Top level of the command frame receiver: framing parser plus result register.
// Depends on ucfr_pkg, ucfr_parser and ucfr_out_reg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------
//   in      | input     | in_valid_i / in_stall_o | rx_byte_i
//   out     | output    | out_valid_o/out_stall_i | command_o, first_arg_o, second_arg_o
//   cfg     | input     | cfg_we_i                | cfg_wdata_i (node address)
//
// One byte per cycle while in_stall_o is low; a completed frame's result appears the
// cycle after its last byte. The one-entry result register sets the figure; in_stall_o
// rises only while it holds an item and out_stall_i is high.
// Reset clears position, stored bytes and result valid; node address resets to 1.
`timescale 1ns / 1ps

module uart_command_frame_receiver import ucfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] command_o,
  output logic [7:0] first_arg_o,
  output logic [7:0] second_arg_o
);

  logic       accept;
  logic       done;
  frame_res_t res;
  frame_res_t res_out;

  assign accept = in_valid_i & ~in_stall_o;

  ucfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .done_o      (done),
    .res_o       (res)
  );

  ucfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept & done),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .busy_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign command_o    = res_out.command;
  assign first_arg_o  = res_out.first_arg;
  assign second_arg_o = res_out.second_arg;

`ifndef ASSERT_OFF
  // Input only backs up behind a held result
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("in_stall_o high with no result held");

  // Second argument only carries data for command 3
  a_second_arg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (command_o != CMD_3)) |-> (second_arg_o == 8'h00))
    else $error("second_arg nonzero for a command without it");

  // A new result follows an accepted byte
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without an accepted item");
`endif

endmodule

FILE: rtl/ucfr_parser.sv
// Framing state machine: tracks the byte position, stores identifier and
// argument bytes, holds the node address register. Uses ucfr_pkg.
`timescale 1ns / 1ps

module ucfr_parser import ucfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       done_o,
  output frame_res_t res_o
);

  pos_e       pos_q, pos_d;
  logic [3:0] addr_q;
  logic [7:0] id_q;
  logic [7:0] arg0_q;
  logic [7:0] arg1_q;
  logic [2:0] cmd;
  logic       at_last;

  assign cmd     = id_q[6:4];
  assign at_last = (pos_q == last_pos(cmd));

  // Next position
  always_comb begin
    pos_d = pos_q;
    case (pos_q)
      POS_SYNC: begin
        if (rx_byte_i == SyncByte) pos_d = POS_ID;
        else if (rx_byte_i == BreakByte) pos_d = POS_SYNC;
        else pos_d = POS_BREAK;
      end
      POS_ID: begin
        pos_d = (rx_byte_i[3:0] == addr_q) ? POS_ARG0 : POS_BREAK;
      end
      POS_ARG0: pos_d = at_last ? POS_BREAK : POS_ARG1;
      POS_ARG1: pos_d = at_last ? POS_BREAK : POS_CKSUM;
      POS_CKSUM: pos_d = POS_BREAK;
      default: begin
        // break position, and any stray code
        pos_d = (rx_byte_i == BreakByte) ? POS_SYNC : POS_BREAK;
      end
    endcase
  end

  // Completion and result fields; args come from stored bytes only
  always_comb begin
    case (pos_q)
      POS_ARG0, POS_ARG1, POS_CKSUM: done_o = at_last;
      default:                       done_o = 1'b0;
    endcase
    res_o.command    = cmd;
    res_o.first_arg  = has_first_arg(cmd) ? arg0_q : 8'h00;
    res_o.second_arg = has_second_arg(cmd) ? arg1_q : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_BREAK;
      addr_q <= AddrReset;
      id_q   <= 8'h00;
      arg0_q <= 8'h00;
      arg1_q <= 8'h00;
    end else begin
      if (cfg_we_i) addr_q <= cfg_wdata_i;
      if (accept_i) begin
        pos_q <= pos_d;
        if (pos_q == POS_ID) id_q <= rx_byte_i;
        if (pos_q == POS_ARG0) arg0_q <= rx_byte_i;
        if (pos_q == POS_ARG1) arg1_q <= rx_byte_i;
      end
    end
  end

endmodule

FILE: rtl/ucfr_out_reg.sv
// Result register with valid/stall handshake; frees the input side as soon
// as the held item is taken. Uses ucfr_pkg for the result struct.
`timescale 1ns / 1ps

module ucfr_out_reg import ucfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  frame_res_t res_i,
  input  logic       out_stall_i,
  output logic       busy_o,
  output logic       out_valid_o,
  output frame_res_t res_o
);

  logic       valid_q, valid_d;
  frame_res_t res_q;

  // busy: holding an item that the sink is not taking this cycle
  assign busy_o = valid_q & out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for uart_command_frame_receiver: a queue-fed byte driver,
// a result monitor and a frame predictor. Depends on ucfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module testbench;
  import ucfr_pkg::*;

  localparam int IdleLimit    = 1000;
  localparam int SettleCycles = 4;
  localparam int PhaseBytes   = 85;
  localparam int NumPhases    = 8;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] command_o;
  logic [7:0] first_arg_o;
  logic [7:0] second_arg_o;

  // Frame predictor state
  logic [2:0] frame_pos  = POS_BREAK;
  logic [7:0] id_seen    = 8'h00;
  logic [7:0] args_seen[2] = '{8'h00, 8'h00};
  logic [3:0] node_addr  = AddrReset;

  logic [7:0] pend_bytes[$];
  frame_res_t frames_due[$];

  bit byte_taken;
  bit res_taken;
  int quiet_cycles;
  int errors;
  int send_idle_pct;
  int stall_pct;

  int send_plan[4]  = '{0, 76, 0, 20};
  int stall_plan[4] = '{0, 0, 76, 20};
  logic [3:0] addr_plan[NumPhases] = '{4'h0, 4'hF, 4'h6, 4'hA, 4'hF, 4'h0, 4'h3, 4'h1};

  uart_command_frame_receiver DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .command_o   (command_o),
    .first_arg_o (first_arg_o),
    .second_arg_o(second_arg_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int bytes_in_frame(input logic [2:0] op);
    case (op)
      CMD_1, CMD_5, CMD_6: return 5;
      CMD_3:               return 6;
      default:             return 4;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [2:0] p;
    logic [2:0] op;
    frame_res_t r;
    p = (frame_pos > POS_CKSUM) ? POS_BREAK : frame_pos;
    case (p)
      POS_BREAK: frame_pos = (b == BreakByte) ? POS_SYNC : POS_BREAK;
      POS_SYNC: begin
        if (b == SyncByte) frame_pos = POS_ID;
        else if (b == BreakByte) frame_pos = POS_SYNC;  // fresh break
        else frame_pos = POS_BREAK;
      end
      POS_ID: begin
        id_seen   = b;
        frame_pos = (b[3:0] == node_addr) ? POS_ARG0 : POS_BREAK;
      end
      default: begin
        if (p == POS_ARG0) args_seen[0] = b;
        else if (p == POS_ARG1) args_seen[1] = b;
        op = id_seen[6:4];
        if (int'(p) + 1 < bytes_in_frame(op)) begin
          frame_pos = p + 3'd1;
        end else begin
          frame_pos    = POS_BREAK;
          r.command    = op;
          r.first_arg  = (op inside {CMD_1, CMD_3, CMD_5, CMD_6}) ? args_seen[0] : 8'h00;
          r.second_arg = (op == CMD_3) ? args_seen[1] : 8'h00;
          frames_due.push_back(r);
        end
      end
    endcase
  endtask

  task automatic check_result();
    frame_res_t want;
    if (frames_due.size() == 0) begin
      report_mismatch("result with none expected, command", int'(command_o), 0);
      return;
    end
    want = frames_due.pop_front();
    if (command_o !== want.command)
      report_mismatch("command", int'(command_o), int'(want.command));
    if (first_arg_o !== want.first_arg)
      report_mismatch("first_arg", int'(first_arg_o), int'(want.first_arg));
    if (second_arg_o !== want.second_arg)
      report_mismatch("second_arg", int'(second_arg_o), int'(want.second_arg));
  endtask

  // Monitor: acceptance on both channels, prediction and checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      byte_taken = in_valid_i && !in_stall_o;
      res_taken  = out_valid_o && !out_stall_i;
      if (byte_taken) begin
        parse_byte(rx_byte_i);
        void'(pend_bytes.pop_front());
      end
      if (res_taken) check_result();
      quiet_cycles = (byte_taken || res_taken || cfg_we_i) ? 0 : quiet_cycles + 1;
    end
  end

  // Driver: a stalled item holds until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      rx_byte_i   <= 8'h00;
      out_stall_i <= 1'b0;
    end else begin
      if (!(in_valid_i && !byte_taken)) begin
        if (pend_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= pend_bytes[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < IdleLimit) @(negedge clk_i);
    $display("tb: failure");
    $finish;
  end

  task automatic push_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[k]) pend_bytes.push_back(bytes[k]);
  endtask

  task automatic push_frame(input logic [7:0] id);
    pend_bytes.push_back(BreakByte);
    pend_bytes.push_back(SyncByte);
    pend_bytes.push_back(id);
    repeat (bytes_in_frame(id[6:4]) - 3) pend_bytes.push_back(8'($urandom));
  endtask

  // Mostly well-formed frames with random content, the rest broken frames and noise
  task automatic fill_random(input int n);
    int start;
    int kind;
    logic [7:0] id;
    start = pend_bytes.size();
    while (pend_bytes.size() - start < n) begin
      kind = $urandom_range(99);
      id   = {1'($urandom), 3'($urandom), node_addr};
      if (kind < 65) begin
        push_frame(id);
      end else if (kind < 75) begin
        repeat ($urandom_range(3, 1)) pend_bytes.push_back(BreakByte);
        push_frame(id);
      end else if (kind < 85) begin
        id[3:0] = node_addr + 4'($urandom_range(15, 1));
        push_frame(id);
      end else if (kind < 92) begin
        pend_bytes.push_back(BreakByte);
        pend_bytes.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(4, 1)) pend_bytes.push_back(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pend_bytes.size() != 0 || frames_due.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 4'h0;
    errors       = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed, at the reset address: bad break bytes, repeated break, extreme
    // arguments with bit 7 of the identifier set, bad sync, address mismatch
    @(posedge clk_i);
    push_bytes('{8'hFF, SyncByte,
                 BreakByte, BreakByte, SyncByte, 8'hB1, 8'h00, 8'hFF, 8'hAB,
                 BreakByte, 8'hAA,
                 BreakByte, SyncByte, 8'h3E,
                 BreakByte, SyncByte, 8'h71, 8'h00,
                 BreakByte, SyncByte, 8'h11, 8'hFF, 8'h5A});
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= addr_plan[ph];
      @(posedge clk_i);
      node_addr     = addr_plan[ph];
      send_idle_pct = send_plan[ph % 4];
      stall_pct     = stall_plan[ph % 4];
      fill_random(PhaseBytes);
      @(negedge clk_i) cfg_we_i <= 1'b0;
      wait_drained();
    end

    if (frames_due.size() != 0) report_mismatch("frames left over", frames_due.size(), 0);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
rtl/ucfr_pkg.sv
rtl/ucfr_parser.sv
rtl/ucfr_out_reg.sv
rtl/uart_command_frame_receiver.sv
tb/sv/testbench.sv
